/* src/hbc_pkg.sv */
// hbc_pkg: types, codes and constants shared by the hashed block buffer cache.
// Depends on nothing.
package hbc_pkg;

    localparam int NUM_BUFFERS_DEF = 32;
    localparam int NUM_BUCKETS_DEF = 29;

    localparam int DEVICE_W = 16;
    localparam int BLOCK_W  = 32;
    localparam int INDEX_W  = 5;
    localparam int BUCKET_W = 5;
    localparam int COUNT_W  = 8;
    localparam int TICK_W   = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_LOOKUP  = 2'd0,
        OP_PIN     = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOBUF = 2'd1,
        ST_UNDER = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_SCAN,
        S_LK_WB,
        S_RMW_RD,
        S_RMW_WB,
        S_EMIT
    } fsm_t;

    typedef struct packed {
        op_t                 op;
        logic [DEVICE_W-1:0] device;
        logic [BLOCK_W-1:0]  block_number;
        logic [INDEX_W-1:0]  buffer_index;
    } in_req_t;

    typedef struct packed {
        logic [INDEX_W-1:0] result_buffer;
        logic               hit;
        logic               fill_needed;
        status_t            status;
    } out_rsp_t;

    typedef struct packed {
        logic [DEVICE_W-1:0] tag_device;
        logic [BLOCK_W-1:0]  tag_block;
        logic                assigned;
        logic                contents_valid;
        logic [COUNT_W-1:0]  ref_count;
        logic [TICK_W-1:0]   alloc_tick;
        logic [BUCKET_W-1:0] bucket;
    } buf_entry_t;

endpackage

/* src/hbc_store.sv */
// hbc_store: buffer record memory, one write and one registered read per cycle.
// Entries never written read as all zero. Depends on hbc_pkg.
module hbc_store import hbc_pkg::*; #(
    parameter int NUM_BUFFERS = NUM_BUFFERS_DEF,
    parameter int AW          = $clog2(NUM_BUFFERS)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output buf_entry_t    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  buf_entry_t    wr_data
);

    buf_entry_t             mem [NUM_BUFFERS];
    buf_entry_t             rd_raw_reg;
    logic                   rd_written_reg;
    logic [NUM_BUFFERS-1:0] written_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_raw_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_written_reg ? rd_raw_reg : '0;

endmodule

/* src/hbc_mod.sv */
// hbc_mod: block number modulo bucket count in two registered steps.
// Bytes fold through constant residues of 2^(8k); a reciprocal multiply reduces the sum.
// Depends on hbc_pkg.
module hbc_mod import hbc_pkg::*; #(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [BLOCK_W-1:0]  dividend,
    output logic                done,
    output logic [BUCKET_W-1:0] remainder
);

    localparam int FW  = 15;
    localparam int RSH = FW + BUCKET_W;
    localparam int RW  = RSH + 1;
    localparam int QW  = FW + 1;
    localparam int PW  = FW + RW;

    function automatic int pow2_mod(input int e);
        int r;
        r = 1 % NUM_BUCKETS;
        for (int i = 0; i < e; i++) begin
            r = (2 * r) % NUM_BUCKETS;
        end
        return r;
    endfunction

    localparam logic [FW-1:0] RES0    = FW'(pow2_mod(0));
    localparam logic [FW-1:0] RES1    = FW'(pow2_mod(8));
    localparam logic [FW-1:0] RES2    = FW'(pow2_mod(16));
    localparam logic [FW-1:0] RES3    = FW'(pow2_mod(24));
    localparam logic [RW-1:0] RECIP   = RW'((2 ** RSH + NUM_BUCKETS - 1) / NUM_BUCKETS);
    localparam logic [QW-1:0] DIVISOR = QW'(NUM_BUCKETS);

    logic                v1_reg, v1_next;
    logic                done_reg, done_next;
    logic [FW-1:0]       fold_reg, fold_next;
    logic [BUCKET_W-1:0] rem_reg, rem_next;
    logic [FW-1:0]       folded;
    logic [PW-1:0]       prod;
    logic [QW-1:0]       quo, qd, diff;

    always_comb begin
        // folded sum stays below 2^15 for any bucket count up to 32
        folded = FW'(dividend[7:0]) * RES0 + FW'(dividend[15:8]) * RES1 +
                 FW'(dividend[23:16]) * RES2 + FW'(dividend[31:24]) * RES3;
        prod   = PW'(fold_reg) * PW'(RECIP);
        quo    = prod[PW-1:RSH];
        qd     = quo * DIVISOR;
        diff   = QW'(fold_reg) - qd;

        v1_next   = start;
        done_next = v1_reg;
        fold_next = start ? folded : fold_reg;
        rem_next  = v1_reg ? BUCKET_W'(diff) : rem_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v1_reg   <= v1_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        fold_reg <= fold_next;
        rem_reg  <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* src/hashed_block_buffer_cache.sv */
// Hashed block buffer cache: lookup with oldest-allocation-timestamp recycling, pin, release and no-op.
// Lookup: the bucket remainder from hbc_mod, then one pass over the record memory
// (one entry per cycle), then the writeback of the hit or victim entry and the result.
// Pin, release and no-op: read-modify-write of one entry.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset (synchronous, active low) clears control state and entry valid bits at once.
module hashed_block_buffer_cache import hbc_pkg::*; #(
    parameter int NUM_BUFFERS = NUM_BUFFERS_DEF,
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_req_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output out_rsp_t m_data
);

    localparam int AW = $clog2(NUM_BUFFERS);
    localparam int CW = $clog2(NUM_BUFFERS + 1);

    fsm_t                state_reg, state_next;
    in_req_t             req_reg, req_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [CW-1:0]       rd_cnt_reg, rd_cnt_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [AW-1:0]       rd_idx_reg, rd_idx_next;
    logic                hit_found_reg, hit_found_next;
    logic [AW-1:0]       hit_idx_reg, hit_idx_next;
    buf_entry_t          hit_entry_reg, hit_entry_next;
    logic                vic_found_reg, vic_found_next;
    logic [AW-1:0]       vic_idx_reg, vic_idx_next;
    logic                vic_own_reg, vic_own_next;
    logic [BUCKET_W-1:0] vic_bucket_reg, vic_bucket_next;
    logic [TICK_W-1:0]   vic_tick_reg, vic_tick_next;
    out_rsp_t            res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    out_rsp_t            m_data_reg, m_data_next;

    logic                rd_en, wr_en;
    logic [AW-1:0]       rd_addr, wr_addr;
    buf_entry_t          rd_data, wr_data;
    logic                mod_start, mod_done;
    logic [BUCKET_W-1:0] bucket_k;

    logic                accept, issue, in_range, own, tag_match, better;

    hbc_store #(
        .NUM_BUFFERS (NUM_BUFFERS),
        .AW          (AW)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    hbc_mod #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (s_data.block_number),
        .done      (mod_done),
        .remainder (bucket_k)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign mod_start = accept && (s_data.op == OP_LOOKUP);
    assign issue     = (rd_cnt_reg != CW'(NUM_BUFFERS));
    assign in_range  = (32'(req_reg.buffer_index) < 32'(NUM_BUFFERS));

    assign own       = (rd_data.bucket == bucket_k);
    assign tag_match = rd_data.assigned && own &&
                       (rd_data.tag_device == req_reg.device) &&
                       (rd_data.tag_block == req_reg.block_number);
    assign better    = !vic_found_reg || (own && !vic_own_reg) ||
                       ((own == vic_own_reg) &&
                        ((rd_data.bucket < vic_bucket_reg) ||
                         ((rd_data.bucket == vic_bucket_reg) &&
                          (rd_data.alloc_tick <= vic_tick_reg))));

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        tick_next       = tick_reg;
        rd_cnt_next     = rd_cnt_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_entry_next  = hit_entry_reg;
        vic_found_next  = vic_found_reg;
        vic_idx_next    = vic_idx_reg;
        vic_own_next    = vic_own_reg;
        vic_bucket_next = vic_bucket_reg;
        vic_tick_next   = vic_tick_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        rd_en           = 1'b0;
        rd_addr         = AW'(req_reg.buffer_index);
        wr_en           = 1'b0;
        wr_addr         = AW'(req_reg.buffer_index);
        wr_data         = rd_data;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    req_next       = s_data;
                    rd_cnt_next    = '0;
                    hit_found_next = 1'b0;
                    vic_found_next = 1'b0;
                    if (s_data.op == OP_LOOKUP) begin
                        tick_next  = tick_reg + 1'b1;
                        state_next = S_MOD;
                    end else begin
                        state_next = S_RMW_RD;
                    end
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (issue) begin
                    rd_en       = 1'b1;
                    rd_addr     = rd_cnt_reg[AW-1:0];
                    rd_vld_next = 1'b1;
                    rd_idx_next = rd_cnt_reg[AW-1:0];
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                if (rd_vld_reg) begin
                    if (tag_match && !hit_found_reg) begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = rd_idx_reg;
                        hit_entry_next = rd_data;
                    end
                    if ((rd_data.ref_count == '0) && better) begin
                        vic_found_next  = 1'b1;
                        vic_idx_next    = rd_idx_reg;
                        vic_own_next    = own;
                        vic_bucket_next = rd_data.bucket;
                        vic_tick_next   = rd_data.alloc_tick;
                    end
                end
                if (!issue && !rd_vld_reg) begin
                    state_next = S_LK_WB;
                end
            end
            S_LK_WB: begin
                res_next.hit         = 1'b0;
                res_next.fill_needed = 1'b0;
                res_next.status      = ST_OK;
                if (hit_found_reg) begin
                    wr_en                  = 1'b1;
                    wr_addr                = hit_idx_reg;
                    wr_data                = hit_entry_reg;
                    wr_data.contents_valid = 1'b1;
                    if (hit_entry_reg.ref_count != COUNT_MAX) begin
                        wr_data.ref_count = hit_entry_reg.ref_count + 1'b1;
                    end
                    res_next.result_buffer = INDEX_W'(hit_idx_reg);
                    res_next.hit           = 1'b1;
                    res_next.fill_needed   = !hit_entry_reg.contents_valid;
                end else if (vic_found_reg) begin
                    wr_en                  = 1'b1;
                    wr_addr                = vic_idx_reg;
                    wr_data.tag_device     = req_reg.device;
                    wr_data.tag_block      = req_reg.block_number;
                    wr_data.assigned       = 1'b1;
                    wr_data.contents_valid = 1'b1;
                    wr_data.ref_count      = COUNT_W'(1);
                    wr_data.alloc_tick     = tick_reg;
                    wr_data.bucket         = bucket_k;
                    res_next.result_buffer = INDEX_W'(vic_idx_reg);
                    res_next.fill_needed   = 1'b1;
                end else begin
                    res_next.result_buffer = '0;
                    res_next.status        = ST_NOBUF;
                end
                state_next = S_EMIT;
            end
            S_RMW_RD: begin
                rd_en      = 1'b1;
                state_next = S_RMW_WB;
            end
            S_RMW_WB: begin
                res_next.result_buffer = req_reg.buffer_index;
                res_next.hit           = 1'b0;
                res_next.fill_needed   = 1'b0;
                res_next.status        = ST_OK;
                if (in_range && (req_reg.op == OP_PIN) &&
                    (rd_data.ref_count != COUNT_MAX)) begin
                    wr_en             = 1'b1;
                    wr_data.ref_count = rd_data.ref_count + 1'b1;
                end
                if (in_range && (req_reg.op == OP_RELEASE)) begin
                    if (rd_data.ref_count == '0) begin
                        res_next.status = ST_UNDER;
                    end else begin
                        wr_en             = 1'b1;
                        wr_data.ref_count = rd_data.ref_count - 1'b1;
                    end
                end
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            tick_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tick_reg    <= tick_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        rd_cnt_reg     <= rd_cnt_next;
        rd_idx_reg     <= rd_idx_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_entry_reg  <= hit_entry_next;
        vic_found_reg  <= vic_found_next;
        vic_idx_reg    <= vic_idx_next;
        vic_own_reg    <= vic_own_next;
        vic_bucket_reg <= vic_bucket_next;
        vic_tick_reg   <= vic_tick_next;
        res_reg        <= res_next;
        m_data_reg     <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg != S_IDLE)
        else $error("request accepted but controller stayed idle");

    a_no_rd_wr_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rd_en && wr_en))
        else $error("record read and write in the same cycle");

    a_wr_in_writeback: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == S_LK_WB || state_reg == S_RMW_WB))
        else $error("record write outside a writeback state");

    a_hit_is_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.hit || m_data.fill_needed) |-> m_data.status == ST_OK)
        else $error("hit or fill reported with an error status");

    a_emit_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EMIT && (!m_valid_reg || m_ready) |=> m_valid_reg)
        else $error("result not presented after emit");

endmodule

/* test/hashed_block_buffer_cache_test.sv */
// hashed_block_buffer_cache_test: self-checking bench for the hashed block buffer cache.
// Runs directed and random lookup, pin, release and no-op requests with idling on both sides,
// and predicts every result in place. Depends on hbc_pkg and hashed_block_buffer_cache.
module hashed_block_buffer_cache_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hbc_pkg::*;

    localparam int NUM_BUF          = NUM_BUFFERS_DEF;
    localparam int NUM_BKT          = NUM_BUCKETS_DEF;
    localparam int POOL_SIZE        = 48;
    localparam int RANDOM_ITEMS     = 270;
    localparam int QUIET_ITEMS      = 60;
    localparam int CYCLE_LIMIT      = 600000;
    localparam int SETTLE_CYCLES    = 64;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int MAX_PRINTED      = 40;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    in_req_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    out_rsp_t m_data;

    // cache image kept by the bench
    logic [DEVICE_W-1:0] cache_dev    [NUM_BUF] = '{default: '0};
    logic [BLOCK_W-1:0]  cache_blk    [NUM_BUF] = '{default: '0};
    bit                  cache_used   [NUM_BUF] = '{default: 1'b0};
    bit                  cache_filled [NUM_BUF] = '{default: 1'b0};
    logic [COUNT_W-1:0]  cache_refs   [NUM_BUF] = '{default: '0};
    logic [TICK_W-1:0]   cache_stamp  [NUM_BUF] = '{default: '0};
    int                  cache_bucket [NUM_BUF] = '{default: 0};
    logic [TICK_W-1:0]   cache_clock  = '0;

    out_rsp_t           pending_results[$];
    logic [BLOCK_W-1:0] block_pool [POOL_SIZE];
    int                 error_count = 0;
    int                 cycle_count = 0;
    int                 send_calm   = 0;
    bit                 quiet       = 1'b0;
    bit                 long_hold   = 1'b0;

    hashed_block_buffer_cache u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("hashed_block_buffer_cache verification failed");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    // unused buffer of a bucket with the least tick, ties to the highest index
    function automatic int oldest_free(input int bucket);
        int pick;
        pick = -1;
        for (int i = 0; i < NUM_BUF; i++) begin
            if (cache_bucket[i] == bucket && cache_refs[i] == 0 &&
                (pick < 0 || cache_stamp[i] <= cache_stamp[pick])) begin
                pick = i;
            end
        end
        return pick;
    endfunction

    function automatic out_rsp_t predict_cache(input in_req_t req);
        out_rsp_t rsp;
        int       bkt;
        int       pick;
        rsp.result_buffer = req.buffer_index;
        rsp.hit           = 1'b0;
        rsp.fill_needed   = 1'b0;
        rsp.status        = ST_OK;
        case (req.op)
            OP_LOOKUP: begin
                bkt         = int'(req.block_number % NUM_BKT);
                cache_clock = cache_clock + 1'b1;
                pick        = -1;
                for (int i = 0; i < NUM_BUF; i++) begin
                    if (pick < 0 && cache_bucket[i] == bkt && cache_used[i] &&
                        cache_dev[i] == req.device && cache_blk[i] == req.block_number) begin
                        pick = i;
                    end
                end
                if (pick >= 0) begin
                    if (cache_refs[pick] != COUNT_MAX) begin
                        cache_refs[pick] = cache_refs[pick] + 1'b1;
                    end
                    rsp.hit            = 1'b1;
                    rsp.fill_needed    = !cache_filled[pick];
                    cache_filled[pick] = 1'b1;
                    rsp.result_buffer  = INDEX_W'(pick);
                end else begin
                    pick = oldest_free(bkt);
                    for (int b = 0; b < NUM_BKT && pick < 0; b++) begin
                        if (b != bkt) begin
                            pick = oldest_free(b);
                        end
                    end
                    if (pick < 0) begin
                        rsp.status        = ST_NOBUF;
                        rsp.result_buffer = '0;
                    end else begin
                        cache_dev[pick]    = req.device;
                        cache_blk[pick]    = req.block_number;
                        cache_used[pick]   = 1'b1;
                        cache_refs[pick]   = COUNT_W'(1);
                        cache_stamp[pick]  = cache_clock;
                        cache_bucket[pick] = bkt;
                        cache_filled[pick] = 1'b1;
                        rsp.fill_needed    = 1'b1;
                        rsp.result_buffer  = INDEX_W'(pick);
                    end
                end
            end
            OP_PIN: begin
                if (req.buffer_index < NUM_BUF && cache_refs[req.buffer_index] != COUNT_MAX) begin
                    cache_refs[req.buffer_index] = cache_refs[req.buffer_index] + 1'b1;
                end
            end
            OP_RELEASE: begin
                if (req.buffer_index < NUM_BUF) begin
                    if (cache_refs[req.buffer_index] == 0) begin
                        rsp.status = ST_UNDER;
                    end else begin
                        cache_refs[req.buffer_index] = cache_refs[req.buffer_index] - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    function automatic in_req_t make_req(input op_t op, input logic [DEVICE_W-1:0] dev,
                                         input logic [BLOCK_W-1:0] blk, input int idx);
        in_req_t req;
        req.op           = op;
        req.device       = dev;
        req.block_number = blk;
        req.buffer_index = INDEX_W'(idx);
        return req;
    endfunction

    // releases gain weight over lookups as more buffers are held
    function automatic in_req_t random_req();
        in_req_t req;
        int      roll;
        int      live[$];
        for (int i = 0; i < NUM_BUF; i++) begin
            if (cache_refs[i] != 0) begin
                live.push_back(i);
            end
        end
        req  = make_req(OP_NOP, DEVICE_W'($urandom), $urandom, $urandom_range(0, NUM_BUF - 1));
        roll = $urandom_range(0, 99);
        if (roll >= 4 && roll < 12) begin
            req.op = OP_PIN;
        end else if (roll >= 12 && roll < 32 + 2 * live.size()) begin
            req.op = OP_RELEASE;
            if (live.size() != 0 && $urandom_range(0, 9) != 0) begin
                req.buffer_index = INDEX_W'(live[$urandom_range(0, live.size() - 1)]);
            end
        end else if (roll >= 12) begin
            req.op = OP_LOOKUP;
            if ($urandom_range(0, 7) != 0) begin
                req.block_number = block_pool[$urandom_range(0, POOL_SIZE - 1)];
                req.device       = DEVICE_W'($urandom_range(0, 2));
                if ($urandom_range(0, 3) == 0) begin
                    req.device = '1;
                end
            end
        end
        return req;
    endfunction

    task automatic fill_block_pool();
        for (int i = 0; i < POOL_SIZE; i++) begin
            case (i % 4)
                0: block_pool[i] = $urandom_range(0, 63);
                1: block_pool[i] = NUM_BKT * $urandom_range(0, 4000) + $urandom_range(0, 2);
                2: block_pool[i] = $urandom;
                default: block_pool[i] = 32'hFFFF_FFFF - $urandom_range(0, 40);
            endcase
        end
    endtask

    task automatic send_request(input in_req_t req);
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        pending_results.push_back(predict_cache(req));
        if (send_calm > 0) begin
            send_calm--;
        end else if ($urandom_range(0, 63) == 0) begin
            send_calm = $urandom_range(20, 80);
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic release_all();
        for (int i = 0; i < NUM_BUF; i++) begin
            while (cache_refs[i] != 0) begin
                send_request(make_req(OP_RELEASE, DEVICE_W'($urandom), $urandom, i));
            end
        end
    endtask

    task automatic test_directed();
        send_request(make_req(OP_LOOKUP, 16'h0000, 32'h0000_0000, 0));
        send_request(make_req(OP_LOOKUP, 16'h0000, 32'h0000_0000, 31));
        send_request(make_req(OP_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 0));
        send_request(make_req(OP_LOOKUP, 16'hFFFF, 32'h0000_0000, 0));
        send_request(make_req(OP_LOOKUP, 16'h0000, 32'd29, 0));
        send_request(make_req(OP_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 31));
        send_request(make_req(OP_RELEASE, 16'h0000, 32'h0, 31));
        send_request(make_req(OP_RELEASE, 16'h0000, 32'h0, 31));
        send_request(make_req(OP_RELEASE, 16'hFFFF, 32'hFFFF_FFFF, 31));
        send_request(make_req(OP_PIN, 16'h0000, 32'h0, 0));
        send_request(make_req(OP_RELEASE, 16'h0000, 32'h0, 0));
        send_request(make_req(OP_RELEASE, 16'h0000, 32'h0, 0));
        send_request(make_req(OP_PIN, 16'hFFFF, 32'hFFFF_FFFF, 31));
        send_request(make_req(OP_NOP, 16'hFFFF, 32'hFFFF_FFFF, 31));
        send_request(make_req(OP_NOP, 16'h0000, 32'h0, 0));
        send_request(make_req(OP_LOOKUP, 16'h0000, 32'h0000_0000, 5));
        send_request(make_req(OP_RELEASE, 16'h0000, 32'h0, 31));
        send_request(make_req(OP_RELEASE, 16'h0000, 32'h0, 31));
        // recycle in bucket 0 must now skip the freshly stamped buffer
        send_request(make_req(OP_LOOKUP, 16'h0000, 32'd58, 0));
        send_request(make_req(OP_LOOKUP, 16'h0000, 32'h0000_0000, 0));
        release_all();
        wait_drain();
    endtask

    task automatic test_exhaustion();
        for (int i = 0; i < NUM_BUF + 2; i++) begin
            send_request(make_req(OP_LOOKUP, 16'h00A5, 32'h0000_1000 + i, i % NUM_BUF));
        end
        send_request(make_req(OP_LOOKUP, 16'h00A5, 32'h0000_1000, 0));
        release_all();
        wait_drain();
    endtask

    // buffer 9 is left held at the saturated count
    task automatic test_saturation();
        for (int i = 0; i < int'(COUNT_MAX) + 2; i++) begin
            send_request(make_req(OP_PIN, DEVICE_W'($urandom), $urandom, 9));
        end
        send_request(make_req(OP_RELEASE, 16'h0000, 32'h0, 9));
        send_request(make_req(OP_PIN, 16'h0000, 32'h0, 9));
        wait_drain();
    endtask

    task automatic test_backpressure();
        long_hold = 1'b1;
        for (int i = 0; i < 30; i++) begin
            send_request(random_req());
        end
        wait_drain();
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2) begin
                wait_drain();
            end
            if (i == RANDOM_ITEMS - QUIET_ITEMS) begin
                quiet     = 1'b1;
                send_calm = 0;
            end
            send_request(random_req());
        end
        wait_drain();
    endtask

    always @(posedge aclk) begin : rsp_side
        out_rsp_t want;
        int       hold_left;
        int       rsp_calm;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    flag_error("result with no request pending");
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.result_buffer !== want.result_buffer) begin
                        flag_error($sformatf("result_buffer %0d, want %0d",
                                             m_data.result_buffer, want.result_buffer));
                    end
                    if (m_data.hit !== want.hit) begin
                        flag_error($sformatf("hit %b, want %b", m_data.hit, want.hit));
                    end
                    if (m_data.fill_needed !== want.fill_needed) begin
                        flag_error($sformatf("fill_needed %b, want %b",
                                             m_data.fill_needed, want.fill_needed));
                    end
                    if (m_data.status !== want.status) begin
                        flag_error($sformatf("status %0d, want %0d", m_data.status, want.status));
                    end
                end
            end
            if (long_hold) begin
                long_hold = 1'b0;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (rsp_calm > 0) begin
                rsp_calm--;
            end else if (hold_left == 0 && $urandom_range(0, 63) == 0) begin
                rsp_calm = $urandom_range(20, 80);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!quiet && rsp_calm == 0 && $urandom_range(0, 9) == 0) begin
                hold_left = $urandom_range(1, 19) - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        fill_block_pool();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_exhaustion();
        test_saturation();
        test_backpressure();
        test_random_traffic();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", pending_results.size()));
        end
        if (error_count == 0) begin
            $display("hashed_block_buffer_cache verification clean");
        end else begin
            $display("hashed_block_buffer_cache verification failed");
        end
        $finish;
    end

endmodule

/* sim.f */
src/hbc_pkg.sv
src/hbc_store.sv
src/hbc_mod.sv
src/hashed_block_buffer_cache.sv
test/hashed_block_buffer_cache_test.sv
